// File: hw/rtl/quoted_token_splitter_assert.svh
// ---------------------------------------------------------------------------
// quoted_token_splitter assertion macros
// Shared concurrent assertion forms, clocked on clk_i; QTS_ASSERT is disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH

// Check a property outside reset.
`define QTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define QTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: hw/rtl/qts_pkg.sv
// ---------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the quoted token splitter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  // Characters with special meaning
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Result queue depth: room for two items plus one in flight
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTE  = 2'd2,
    MODE_AFTERQ = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_CMD_END   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] tbyte;
    logic       last;
  } item_t;

  // Decoder result for one input byte
  typedef struct packed {
    logic [1:0] num;
    item_t      item0;
    item_t      item1;
    mode_e      mode;
  } decode_t;

endpackage

`default_nettype wire

// File: hw/rtl/qts_decode.sv
// ---------------------------------------------------------------------------
// qts_decode
// Per-byte scanner decision: result items and next scan mode.
// ---------------------------------------------------------------------------
`default_nettype none

module qts_decode import qts_pkg::*; (
  input  mode_e      mode_i,
  input  logic [7:0] byte_i,
  output decode_t    dec_o
);

  // Build one item; the byte field is zero for anything but a token byte
  function automatic item_t make_item(kind_e kind, logic [7:0] b);
    item_t it;
    it.kind  = kind;
    it.tbyte = (kind == KIND_BYTE) ? b : 8'h00;
    it.last  = 1'b0;
    return it;
  endfunction

  logic  idle_has;
  item_t idle_item;
  mode_e idle_mode;

  // Handle the byte as seen from idle mode
  always_comb begin
    idle_has  = 1'b0;
    idle_item = make_item(KIND_CMD_END, CH_NUL);
    idle_mode = MODE_IDLE;
    if (byte_i == CH_NUL) begin
      idle_has = 1'b1;
    end else if (byte_i <= CH_SPACE) begin
      idle_mode = MODE_IDLE;
    end else if (byte_i == CH_QUOTE) begin
      idle_mode = MODE_QUOTE;
    end else begin
      idle_has  = 1'b1;
      idle_item = make_item(KIND_BYTE, byte_i);
      idle_mode = MODE_PLAIN;
    end
  end

  logic     tok_end;
  decode_t  dec;

  // Pick items per mode; a token end is followed by the idle handling
  always_comb begin
    tok_end   = 1'b0;
    dec.num   = 2'd0;
    dec.item0 = make_item(KIND_BYTE, byte_i);
    dec.item1 = idle_item;
    dec.mode  = mode_i;
    case (mode_i)
      MODE_IDLE: begin
        dec.num   = {1'b0, idle_has};
        dec.item0 = idle_item;
        dec.mode  = idle_mode;
      end
      MODE_PLAIN: begin
        if (byte_i <= CH_SPACE) begin
          tok_end = 1'b1;
        end else begin
          dec.num = 2'd1;
        end
      end
      MODE_QUOTE: begin
        if (byte_i < CH_SPACE) begin
          tok_end = 1'b1;
        end else if (byte_i == CH_QUOTE) begin
          dec.mode = MODE_AFTERQ;
        end else begin
          dec.num = 2'd1;
        end
      end
      MODE_AFTERQ: begin
        if (byte_i == CH_QUOTE) begin
          dec.num  = 2'd1;
          dec.mode = MODE_QUOTE;
        end else begin
          tok_end = 1'b1;
        end
      end
      default: begin
        dec.mode = MODE_IDLE;
      end
    endcase
    if (tok_end) begin
      dec.item0 = make_item(KIND_TOKEN_END, CH_NUL);
      dec.num   = idle_has ? 2'd2 : 2'd1;
      dec.mode  = idle_mode;
    end
    // Mark the final item of this byte
    dec.item0.last = (dec.num == 2'd1);
    dec.item1.last = 1'b1;
  end

  assign dec_o = dec;

endmodule

`default_nettype wire

// File: hw/rtl/qts_out_queue.sv
// ---------------------------------------------------------------------------
// qts_out_queue
// Three-entry result queue: takes up to two items a cycle, gives one.
// ---------------------------------------------------------------------------
`default_nettype none

module qts_out_queue import qts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_num_i,
  input  item_t      item0_i,
  input  item_t      item1_i,
  output logic       room2_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output item_t      out_item_o
);

`include "quoted_token_splitter_assert.svh"

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  item_t              ent_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               pop;

  assign pop       = out_valid_o && out_ready_i;
  assign wr_ptr_nx = ptr_inc(wr_ptr_q);

  // Advance pointers and fill count
  always_comb begin
    case (push_num_i)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(push_num_i) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the new items into the entries
  always_ff @(posedge clk_i) begin
    if (push_num_i != 2'd0) begin
      ent_q[wr_ptr_q] <= item0_i;
    end
    if (push_num_i == 2'd2) begin
      ent_q[wr_ptr_nx] <= item1_i;
    end
  end

  assign room2_o     = (count_q <= QCNT_W'(QDEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign out_item_o  = ent_q[rd_ptr_q];

  `QTS_ASSERT(a_no_overflow, (push_num_i == 2'd0) || room2_o, "push into a full queue")
  `QTS_ASSERT(a_count_range, count_q <= QCNT_W'(QDEPTH), "queue count out of range")
  `QTS_ASSERT(a_ptr_gap,
    (count_q == '0 || count_q == QCNT_W'(QDEPTH)) == (wr_ptr_q == rd_ptr_q),
    "pointers disagree with count")

endmodule

`default_nettype wire

// File: hw/rtl/quoted_token_splitter.sv
// ---------------------------------------------------------------------------
// quoted_token_splitter
// Splits a command byte stream into token bytes, token ends, command ends.
// ---------------------------------------------------------------------------
// One byte is accepted per cycle while the queue has room for two items. A
// byte that ends a token and also starts a word or ends the command gives two
// items, others at most one; items leave the three-entry result queue one per
// cycle while out_ready_i is high, through its single read port; input pauses.
// Results are registered in the queue before output. No clearing pass after reset.
`default_nettype none

module quoted_token_splitter import qts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] item_kind_o,
  output logic [7:0] token_byte_o,
  output logic       run_last_o
);

`include "quoted_token_splitter_assert.svh"

  mode_e      mode_q, mode_d;
  decode_t    dec;
  logic       accept;
  logic [1:0] push_num;
  logic       room2;
  item_t      out_item;

  assign accept   = in_valid_i && in_ready_o;
  assign push_num = accept ? dec.num : 2'd0;
  assign mode_d   = accept ? dec.mode : mode_q;

  // Hold the scan mode between bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
    end else begin
      mode_q <= mode_d;
    end
  end

  qts_decode u_decode (
    .mode_i (mode_q),
    .byte_i (in_byte_i),
    .dec_o  (dec)
  );

  qts_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_num_i  (push_num),
    .item0_i     (dec.item0),
    .item1_i     (dec.item1),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item)
  );

  assign in_ready_o   = room2;
  assign item_kind_o  = out_item.kind;
  assign token_byte_o = out_item.tbyte;
  assign run_last_o   = out_item.last;

  `QTS_ASSERT(a_nonbyte_zero,
    out_valid_o && (item_kind_o != KIND_BYTE) |-> (token_byte_o == 8'h00),
    "non-byte item carries a byte")
  `QTS_ASSERT(a_cmd_end_last,
    out_valid_o && (item_kind_o == KIND_CMD_END) |-> run_last_o,
    "command end is not the last item of its byte")
  `QTS_ASSERT(a_nul_to_idle,
    accept && (in_byte_i == CH_NUL) |=> (mode_q == MODE_IDLE),
    "zero byte left the scanner busy")

endmodule

`default_nettype wire
